// File: sv/css_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants for the cosine similarity scorer: request and
// result payloads, and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package css_pkg;

	// element format, signed Q1.15
	localparam int ELEM_WIDTH = 16;
	localparam int FRAC_BITS  = ELEM_WIDTH - 1;

	// one request: an element pair
	typedef struct packed {
		logic signed [ELEM_WIDTH-1:0] pattern_elem;
		logic signed [ELEM_WIDTH-1:0] target_elem;
		logic                         last;
	} item_t;

	// one result
	typedef struct packed {
		logic signed [ELEM_WIDTH-1:0] score;
		logic                         zero_norm;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic acc_en;      // add the accepted pair to the accumulators
		logic clr;         // clear the accumulators
		logic mul_start;   // load the shift-add multiplier
		logic mul_dot;     // multiplier operands: |dot| * |dot| instead of P * T
		logic mul_step;    // one multiplier bit
		logic m_save;      // keep P * T as the divisor
		logic div_start;   // load the divider with dot^2
		logic div_step;    // one quotient bit
		logic sqrt_start;  // load the square root unit with the quotient
		logic sqrt_step;   // one root bit
		logic res_load;    // form the score into the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic zero_norm;   // a squared norm accumulator is zero
	} status_t;

endpackage
`default_nettype wire

// File: sv/css_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// css_ctrl
// Sequencer for the scorer: takes pairs while idle, then steps the shared
// multiplier, the divider and the square root unit, and hands off the result.
// ----------------------------------------------------------------------------
module css_ctrl #(
	parameter int MAX_ELEMENTS = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	input  wire logic             item_last,
	output logic                  item_ready,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output css_pkg::cmd_t         cmd,
	input  wire css_pkg::status_t status
);
	import css_pkg::*;

	localparam int CNT_BITS = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int MW       = 2 * ELEM_WIDTH + CNT_BITS;
	localparam int CW       = $clog2(MW);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_MUL_M = 4'd2;
	localparam logic [3:0] S_SAVE  = 4'd3;
	localparam logic [3:0] S_MUL_D = 4'd4;
	localparam logic [3:0] S_DIV0  = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_SQRT0 = 4'd7;
	localparam logic [3:0] S_SQRT  = 4'd8;
	localparam logic [3:0] S_RES   = 4'd9;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          out_valid_q, out_valid_d;
	logic          item_fire;

	assign item_ready   = (state_q == S_IDLE);
	assign item_fire    = item_valid && item_ready;
	assign result_valid = out_valid_q;

	// next state, step counter and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_fire) begin
					cmd.acc_en = 1'b1;
					if (item_last)
						state_d = S_START;
				end
			end
			S_START: begin
				if (status.zero_norm) begin
					state_d = S_RES;
				end else begin
					cmd.mul_start = 1'b1;
					cnt_d         = CW'(MW - 1);
					state_d       = S_MUL_M;
				end
			end
			S_MUL_M: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q - 1'b1;
				if (cnt_q == '0)
					state_d = S_SAVE;
			end
			S_SAVE: begin
				cmd.m_save    = 1'b1;
				cmd.mul_start = 1'b1;
				cmd.mul_dot   = 1'b1;
				cnt_d         = CW'(MW - 1);
				state_d       = S_MUL_D;
			end
			S_MUL_D: begin
				cmd.mul_step = 1'b1;
				cmd.mul_dot  = 1'b1;
				cnt_d        = cnt_q - 1'b1;
				if (cnt_q == '0)
					state_d = S_DIV0;
			end
			S_DIV0: begin
				cmd.div_start = 1'b1;
				cnt_d         = CW'(2 * FRAC_BITS - 1);
				state_d       = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q - 1'b1;
				if (cnt_q == '0)
					state_d = S_SQRT0;
			end
			S_SQRT0: begin
				cmd.sqrt_start = 1'b1;
				cnt_d          = CW'(FRAC_BITS - 1);
				state_d        = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q - 1'b1;
				if (cnt_q == '0)
					state_d = S_RES;
			end
			S_RES: begin
				// wait for the output register to free up
				if (!out_valid_q || result_ready) begin
					cmd.res_load = 1'b1;
					cmd.clr      = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// output valid flag
	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.res_load)
			out_valid_d = 1'b1;
		else if (result_ready)
			out_valid_d = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/css_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// css_dp
// Datapath: exact accumulators, a shift-add multiplier for P*T and dot^2,
// a restoring divider for dot^2 * 2^(2F) / (P*T), a digit-by-digit square
// root, and the result register with sign and saturation.
// ----------------------------------------------------------------------------
module css_dp #(
	parameter int MAX_ELEMENTS = 4096
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire css_pkg::item_t item,
	input  wire css_pkg::cmd_t  cmd,
	output css_pkg::status_t    status,
	output css_pkg::result_t    result
);
	import css_pkg::*;

	localparam int CNT_BITS = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int DOT_W    = 2 * ELEM_WIDTH + CNT_BITS;
	localparam int SQ_W     = 2 * ELEM_WIDTH - 1 + CNT_BITS;
	localparam int MW       = DOT_W;
	localparam int PW       = 2 * MW;
	localparam int QW       = 2 * FRAC_BITS;
	localparam int PROD_W   = 2 * ELEM_WIDTH;

	localparam logic [FRAC_BITS:0]    MAG_ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
	localparam logic [ELEM_WIDTH-1:0] MAX_POS  = ELEM_WIDTH'((1 << FRAC_BITS) - 1);
	localparam logic [QW-1:0]         BIT_INIT = QW'(1) << (QW - 2);

	// accumulators
	logic signed [DOT_W-1:0] dot_q;
	logic [SQ_W-1:0]         psq_q, tsq_q;
	logic signed [PROD_W-1:0] pt_prod, pp_prod, tt_prod;

	// multiplier
	logic [PW-1:0] a_sh_q, prod_q, m_q;
	logic [MW-1:0] b_sh_q;

	// divider
	logic [PW-1:0] rem_q;
	logic [PW:0]   rem2, m_ext;
	logic [QW-1:0] quo_q;
	logic          full_q;

	// square root
	logic [QW-1:0] x_q, root_q, bit_q, trial;

	// result
	logic             dot_neg;
	logic [DOT_W-1:0] dot_mag;
	logic [FRAC_BITS:0] mag;
	result_t          res_d;

	assign pt_prod = PROD_W'(item.pattern_elem) * PROD_W'(item.target_elem);
	assign pp_prod = PROD_W'(item.pattern_elem) * PROD_W'(item.pattern_elem);
	assign tt_prod = PROD_W'(item.target_elem) * PROD_W'(item.target_elem);

	assign status.zero_norm = (psq_q == '0) || (tsq_q == '0);

	assign dot_neg = dot_q[DOT_W-1];
	assign dot_mag = dot_neg ? (~dot_q + 1'b1) : dot_q;

	// accumulate one pair, clear after the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			psq_q <= '0;
			tsq_q <= '0;
		end else if (cmd.clr) begin
			dot_q <= '0;
			psq_q <= '0;
			tsq_q <= '0;
		end else if (cmd.acc_en) begin
			dot_q <= dot_q + DOT_W'(pt_prod);
			psq_q <= psq_q + SQ_W'(pp_prod[PROD_W-2:0]);
			tsq_q <= tsq_q + SQ_W'(tt_prod[PROD_W-2:0]);
		end
	end

	// shift-add multiplier, one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			prod_q <= '0;
			if (cmd.mul_dot) begin
				a_sh_q <= PW'(dot_mag);
				b_sh_q <= dot_mag;
			end else begin
				a_sh_q <= PW'(psq_q);
				b_sh_q <= MW'(tsq_q);
			end
		end else if (cmd.mul_step) begin
			if (b_sh_q[0])
				prod_q <= prod_q + a_sh_q;
			a_sh_q <= a_sh_q << 1;
			b_sh_q <= b_sh_q >> 1;
		end
		if (cmd.m_save)
			m_q <= prod_q;
	end

	// restoring divider, one quotient bit per cycle
	assign rem2  = {rem_q, 1'b0};
	assign m_ext = {1'b0, m_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q  <= prod_q;
			quo_q  <= '0;
			full_q <= (prod_q >= m_q);
		end else if (cmd.div_step) begin
			if (rem2 >= m_ext) begin
				rem_q <= PW'(rem2 - m_ext);
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= PW'(rem2);
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	// square root, one root bit per cycle
	assign trial = root_q + bit_q;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			x_q    <= quo_q;
			root_q <= '0;
			bit_q  <= BIT_INIT;
		end else if (cmd.sqrt_step) begin
			if (x_q >= trial) begin
				x_q    <= x_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// sign, saturation and zero norm case
	assign mag = full_q ? MAG_ONE : root_q[FRAC_BITS:0];

	always_comb begin
		res_d.zero_norm = status.zero_norm;
		if (status.zero_norm)
			res_d.score = '0;
		else if (dot_neg)
			res_d.score = ELEM_WIDTH'(~mag + 1'b1);
		else if (mag[FRAC_BITS])
			res_d.score = MAX_POS;
		else
			res_d.score = ELEM_WIDTH'(mag);
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load)
			result <= res_d;
	end

endmodule
`default_nettype wire

// File: sv/cosine_similarity_score.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cosine_similarity_score
// Cosine similarity of two vectors fed one element pair per request, signed
// Q1.15 in and out, exact accumulation, truncated and saturated score.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  request   item_valid / item_ready     item   (pattern_elem, target_elem, last)
//  result    result_valid / result_ready result (score, zero_norm)
//
//  a request without last leaves the block idle; pairs can stream back to back
//  after a last request the block is busy while the bit-serial multiplier
//  (two passes over W = 32 + clog2(MAX_ELEMENTS) bits), the divider and the
//  square root unit run; if a norm is zero it goes straight to the result;
//  it also stays busy while an earlier score still waits to go out
//  the result register lets new pairs be taken while a score waits to go out
//  reset clears the accumulators and the control state
// ----------------------------------------------------------------------------
module cosine_similarity_score #(
	parameter int MAX_ELEMENTS = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire css_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output css_pkg::result_t      result
);
	import css_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer
	css_ctrl #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_last   (item.last),
		.item_ready  (item_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.cmd         (cmd),
		.status      (status)
	);

	// arithmetic
	css_dp #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.status(status),
		.result(result)
	);

endmodule
`default_nettype wire

// File: sv/css_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// css_checker
// Port-level checks for the cosine similarity scorer, bound to the top level.
// ----------------------------------------------------------------------------
module css_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_ready,
	input wire css_pkg::item_t   item,
	input wire logic             result_valid,
	input wire logic             result_ready,
	input wire css_pkg::result_t result
);
	import css_pkg::*;

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// a zero norm result carries a zero score
	a_zero_score: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.zero_norm |-> result.score == '0)
		else $error("zero norm with nonzero score");

	// the block goes busy after the last request of a vector
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.last |=> !item_ready)
		else $error("request taken right after a last request");

	// a new result only comes out of a busy period
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!item_ready))
		else $error("result appeared without a computation");

endmodule

bind cosine_similarity_score css_checker u_css_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.item        (item),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: cosine similarity scorer testbench
// Streams element pairs into the scorer and checks every score against a
// bit-exact software version of the accumulate, root and divide. Directed
// corner vectors come first, then random vectors of several shapes. Both
// handshakes idle in random bursts, and one long result hold-off is used to
// back the block up into its request port.
// ----------------------------------------------------------------------------
module tb;
	import css_pkg::*;

	localparam int DOT_W        = 44;
	localparam int SQ_W         = 43;
	localparam int MAX_SCORE    = (1 << FRAC_BITS) - 1;
	localparam int RANDOM_PAIRS = 700;
	localparam int CALM_TAIL    = 100;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 300;

	typedef enum int {
		VK_RANDOM,
		VK_SAME,
		VK_OPPOSITE,
		VK_SMALL,
		VK_ONE_ZERO,
		VK_CORNER,
		VK_PARALLEL
	} vec_kind_e;

	// expected scores, built from the exact accumulators
	class cosine_tracker;
		logic signed [DOT_W-1:0] dot_acc;
		logic [SQ_W-1:0]         pat_sq;
		logic [SQ_W-1:0]         tgt_sq;
		result_t                 expected_scores[$];
		int n_pairs, n_vectors, n_checked, n_zero, n_saturated, n_errors;

		function new();
			dot_acc     = '0;
			pat_sq      = '0;
			tgt_sq      = '0;
			n_pairs     = 0;
			n_vectors   = 0;
			n_checked   = 0;
			n_zero      = 0;
			n_saturated = 0;
			n_errors    = 0;
		endfunction

		function int outstanding();
			return expected_scores.size();
		endfunction

		// accumulate one accepted pair; on last, work out the score
		function void take_pair(item_t req);
			logic signed [ELEM_WIDTH-1:0]   p, t;
			logic signed [2*ELEM_WIDTH-1:0] pt;
			logic [2*ELEM_WIDTH-1:0]        pp, tt;
			logic [DOT_W-1:0]               mag;
			logic [127:0]                   norm_prod, dot_scaled, lo, hi, mid;
			result_t                        want;
			p  = req.pattern_elem;
			t  = req.target_elem;
			pt = (2*ELEM_WIDTH)'(p) * (2*ELEM_WIDTH)'(t);
			pp = (2*ELEM_WIDTH)'(p) * (2*ELEM_WIDTH)'(p);
			tt = (2*ELEM_WIDTH)'(t) * (2*ELEM_WIDTH)'(t);
			dot_acc = dot_acc + DOT_W'(pt);
			pat_sq  = pat_sq + SQ_W'(pp);
			tgt_sq  = tgt_sq + SQ_W'(tt);
			n_pairs++;
			if (!req.last)
				return;
			n_vectors++;
			want.score     = '0;
			want.zero_norm = 1'b0;
			if (pat_sq == 0 || tgt_sq == 0) begin
				want.zero_norm = 1'b1;
			end else begin
				// largest q with q^2 * P * T <= dot^2 * 2^(2F)
				mag        = dot_acc[DOT_W-1] ? -dot_acc : dot_acc;
				norm_prod  = 128'(pat_sq);
				norm_prod  = norm_prod * 128'(tgt_sq);
				dot_scaled = 128'(mag);
				dot_scaled = (dot_scaled * dot_scaled) << (2 * FRAC_BITS);
				lo = '0;
				hi = 128'(1) << FRAC_BITS;
				while (lo < hi) begin
					mid = lo + (hi - lo + 1) / 2;
					if (mid * mid * norm_prod <= dot_scaled)
						lo = mid;
					else
						hi = mid - 1;
				end
				if (dot_acc < 0) begin
					want.score = -lo[ELEM_WIDTH-1:0];
				end else if (lo > MAX_SCORE) begin
					want.score = MAX_SCORE[ELEM_WIDTH-1:0];
					n_saturated++;
				end else begin
					want.score = lo[ELEM_WIDTH-1:0];
				end
			end
			expected_scores.push_back(want);
			dot_acc = '0;
			pat_sq  = '0;
			tgt_sq  = '0;
		endfunction

		// compare one accepted result with the oldest expected score
		function void match_score(result_t got);
			result_t want;
			if (expected_scores.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("%0t: score %0d zero_norm %0b with nothing expected",
						$time, got.score, got.zero_norm);
				return;
			end
			want = expected_scores.pop_front();
			n_checked++;
			if (want.zero_norm)
				n_zero++;
			if (got.score !== want.score || got.zero_norm !== want.zero_norm) begin
				n_errors++;
				if (n_errors <= 10)
					$display("%0t: score #%0d expected %0d/%0b, got %0d/%0b", $time,
						n_checked, want.score, want.zero_norm, got.score, got.zero_norm);
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	cosine_tracker tracker = new();

	bit idle_on;
	bit pressure_req;
	int gap_pct;
	int random_pairs;

	cosine_similarity_score dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one element pair request, with an optional idle burst ahead of it
	task automatic send_pair(input logic signed [ELEM_WIDTH-1:0] pe,
	                         input logic signed [ELEM_WIDTH-1:0] te, input logic lst);
		item_t req;
		int    gap;
		req.pattern_elem = pe;
		req.target_elem  = te;
		req.last         = lst;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			gap = $urandom_range(1, 14);
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= req;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		tracker.take_pair(req);
	endtask

	function automatic logic signed [ELEM_WIDTH-1:0] corner_value();
		case ($urandom_range(0, 4))
			0:       return {1'b1, {(ELEM_WIDTH-1){1'b0}}};
			1:       return {1'b0, {(ELEM_WIDTH-1){1'b1}}};
			2:       return '0;
			3:       return '1;
			default: return ELEM_WIDTH'(1);
		endcase
	endfunction

	// one vector of the given shape, last on its final pair
	task automatic send_vector(input vec_kind_e kind, input int len);
		logic signed [ELEM_WIDTH-1:0] pe, te;
		int v;
		for (int i = 0; i < len; i++) begin
			pe = ELEM_WIDTH'($urandom());
			te = ELEM_WIDTH'($urandom());
			case (kind)
				VK_SAME:     te = pe;
				VK_OPPOSITE: te = -pe;
				VK_SMALL: begin
					v  = $urandom_range(0, 8);
					pe = ELEM_WIDTH'(v - 4);
					v  = $urandom_range(0, 8);
					te = ELEM_WIDTH'(v - 4);
				end
				VK_ONE_ZERO: begin
					if ($urandom_range(1))
						pe = '0;
					else
						te = '0;
				end
				VK_CORNER: begin
					pe = corner_value();
					te = corner_value();
				end
				VK_PARALLEL: te = pe >>> $urandom_range(0, FRAC_BITS);
				default: ;
			endcase
			send_pair(pe, te, i == len - 1);
			random_pairs++;
		end
	endtask

	// result side: check, then pick ready for the next cycle
	initial begin
		int stall_left;
		int hold_left;
		bit calm;
		stall_left   = 0;
		hold_left    = 0;
		calm         = 1'b0;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				tracker.match_score(result);
			if (pressure_req) begin
				hold_left    = HOLD_CYCLES;
				pressure_req = 1'b0;
			end
			if ($urandom_range(63) == 0)
				calm = 1'($urandom_range(1));
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (idle_on && !calm && $urandom_range(5) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// stimulus
	initial begin
		vec_kind_e kind;
		int len;
		bit pressured;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		idle_on      = 1'b0;
		pressure_req = 1'b0;
		gap_pct      = 0;
		random_pairs = 0;
		pressured    = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners: +1 and -1, zero norms, orthogonal, a known ratio
		send_pair(16'sh7fff, 16'sh7fff, 1'b1);
		send_pair(16'sh8000, 16'sh8000, 1'b1);
		send_pair(16'sh8000, 16'sh7fff, 1'b1);
		send_pair(16'sd0, 16'sd5, 1'b1);
		send_pair(-16'sd7, 16'sd0, 1'b1);
		send_pair(16'sd0, 16'sd0, 1'b1);
		send_pair(16'sd1, 16'sd0, 1'b0);
		send_pair(16'sd0, 16'sd1, 1'b1);
		send_pair(-16'sd1, -16'sd1, 1'b0);
		send_pair(16'sd1, 16'sd1, 1'b1);
		send_pair(16'sd3, 16'sd4, 1'b0);
		send_pair(16'sd4, -16'sd3, 1'b1);
		send_pair(16'sd12345, -16'sd23456, 1'b0);
		send_pair(16'sh8000, 16'sd1, 1'b0);
		send_pair(16'sd77, 16'sh7fff, 1'b1);
		send_pair(16'sd0, 16'sh8000, 1'b0);
		send_pair(16'sh8000, 16'sd0, 1'b1);
		send_pair(16'sd2, 16'sd1, 1'b0);
		send_pair(16'sd1, 16'sd2, 1'b1);

		// random vectors, idling on both sides until the calm tail
		idle_on      = 1'b1;
		random_pairs = 0;
		while (random_pairs < RANDOM_PAIRS) begin
			if (random_pairs >= RANDOM_PAIRS - CALM_TAIL)
				idle_on = 1'b0;
			if (!pressured && random_pairs >= 200) begin
				// hold results off while short vectors keep coming
				pressured    = 1'b1;
				pressure_req = 1'b1;
				gap_pct      = 0;
				for (int v = 0; v < 6; v++)
					send_vector(VK_RANDOM, $urandom_range(1, 3));
			end
			case ($urandom_range(0, 9))
				5:       kind = VK_SAME;
				6:       kind = VK_OPPOSITE;
				7:       kind = VK_SMALL;
				8:       kind = VK_ONE_ZERO;
				9:       kind = ($urandom_range(1)) ? VK_CORNER : VK_PARALLEL;
				default: kind = VK_RANDOM;
			endcase
			len     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
			                                      : $urandom_range(1, 12);
			gap_pct = (idle_on && $urandom_range(0, 2) != 0) ? 25 : 0;
			send_vector(kind, len);
		end
		item_valid <= 1'b0;

		// drain
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d element pairs in %0d vectors; %0d scores checked",
			tracker.n_pairs, tracker.n_vectors, tracker.n_checked);
		$display("%0d zero-norm scores, %0d saturated at +1, %0d mismatches",
			tracker.n_zero, tracker.n_saturated, tracker.n_errors);
		if (tracker.n_errors == 0 && tracker.outstanding() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("timeout with %0d scores outstanding", tracker.outstanding());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
